/* rtl/cba_pkg.sv */
// Shared constants and types for the contiguous block allocator.
// No dependencies; compiled first.
`default_nettype none

package cba_pkg;

  // Storage sizes
  localparam int unsigned MaxBlocks  = 1024;
  localparam int unsigned DirEntries = 16;

  // Derived widths
  localparam int unsigned BlkIdxW = $clog2(MaxBlocks);   // index into the used map
  localparam int unsigned BlkCntW = BlkIdxW + 1;         // counts up to MaxBlocks
  localparam int unsigned SlotIdxW = (DirEntries > 1) ? $clog2(DirEntries) : 1;

  // Fixed field widths
  localparam int unsigned KeyW      = 16;
  localparam int unsigned CountW    = 11;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned StartW    = 10;
  localparam int unsigned LengthW   = 11;
  localparam int unsigned CfgW      = 11;
  localparam int unsigned CfgIdxW   = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTotalBlocks   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgFirstDataBlk  = 1'd1;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] TotalBlocksRst = CfgW'(1024);
  localparam logic [CfgW-1:0] FirstDataRst   = CfgW'(8);

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StDirFull  = 2'd1,
    StNoSpace  = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* rtl/cba_req_if.sv */
// Request channel of the block allocator: file key and run length.
// Depends on cba_pkg.
`default_nettype none

interface cba_req_if;
  logic                           valid;
  logic                           ready;
  logic [cba_pkg::KeyW-1:0]       file_key;
  logic [cba_pkg::CountW-1:0]     block_count;

  modport source (output valid, output file_key, output block_count, input ready);
  modport sink   (input valid, input file_key, input block_count, output ready);
endinterface

`default_nettype wire

/* rtl/cba_rsp_if.sv */
// Response channel of the block allocator: status, slot and start block.
// Depends on cba_pkg.
`default_nettype none

interface cba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cba_pkg::StatusW-1:0]    status;
  logic [cba_pkg::SlotW-1:0]      slot;
  logic [cba_pkg::StartW-1:0]     start_block;

  modport source (output valid, output status, output slot, output start_block,
                  input ready);
  modport sink   (input valid, input status, input slot, input start_block,
                  output ready);
endinterface

`default_nettype wire

/* rtl/contiguous_block_allocator.sv */
// Contiguous first-fit block allocator. Each request word scans a one-bit-per-block
// used map upward from first_data_block, one block a cycle through a single registered
// read port, and stops at the end of the first run of block_count free blocks, or at
// the usable limit with no-space status. A zero block_count, or a first_data_block at
// or past the limit, skips the scan. A found run then claims the lowest free directory
// slot and is marked used, one block a cycle; with no free slot the result is dir-full.
// After reset the map is cleared in a pass during which no request is taken. The next
// request is taken once the current one has finished, even while its response word
// still waits in the output register.
// Depends on cba_pkg, cba_req_if and cba_rsp_if.
`default_nettype none

module contiguous_block_allocator (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [cba_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [cba_pkg::CfgW-1:0]       cfg_data_i,
  cba_req_if.sink                       req_i,
  cba_rsp_if.source                     rsp_o
);
  import cba_pkg::*;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SScan,
    SSlot,
    SMark,
    SResp
  } state_e;

  state_e                state_q;

  // Configuration
  logic [CfgW-1:0]       total_q;
  logic [CfgW-1:0]       first_q;
  logic [CfgW-1:0]       limit;

  // Request and scan registers
  logic [KeyW-1:0]       key_q;
  logic [BlkCntW-1:0]    cnt_q;
  logic [BlkCntW-1:0]    run_q;
  logic [BlkCntW-1:0]    iss_q;       // block whose read is being issued
  logic [BlkCntW-1:0]    chk_q;       // block whose data is in map_rd_q
  logic                  prim_q;
  logic [BlkIdxW-1:0]    start_q;
  logic [BlkIdxW-1:0]    mark_q;
  logic [BlkCntW-1:0]    left_q;
  logic [BlkIdxW-1:0]    clr_q;

  // Result waiting for the output register
  status_e               res_status_q;
  logic [SlotW-1:0]      res_slot_q;
  logic [StartW-1:0]     res_start_q;

  // Output register
  logic                  rsp_vld_q;
  logic [StatusW-1:0]    rsp_status_q;
  logic [SlotW-1:0]      rsp_slot_q;
  logic [StartW-1:0]     rsp_start_q;

  // Directory
  logic [DirEntries-1:0] slot_taken_q;
  logic [KeyW-1:0]       dir_key_q    [DirEntries];
  logic [StartW-1:0]     dir_start_q  [DirEntries];
  logic [LengthW-1:0]    dir_length_q [DirEntries];

  // Used map memory
  logic                  used_map_q [MaxBlocks];
  logic                  map_rd_q;
  logic                  map_we;
  logic [BlkIdxW-1:0]    map_waddr;

  logic                  free_found;
  logic [SlotIdxW-1:0]   free_idx;
  logic                  req_acc;
  logic [BlkCntW-1:0]    run_inc;

  // Usable block count, clipped to the map size
  assign limit = (total_q > CfgW'(MaxBlocks)) ? CfgW'(MaxBlocks) : total_q;

  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == SIdle);
  assign run_inc = run_q + BlkCntW'(1);

  // Lowest free directory slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DirEntries - 1; i >= 0; i--) begin
      if (!slot_taken_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
    end
  end

  // Map write port: clearing pass writes zeros, marking writes ones
  assign map_we    = (state_q == SClear) || (state_q == SMark);
  assign map_waddr = (state_q == SClear) ? clr_q : mark_q;

  // Used map and directory storage
  always_ff @(posedge clk_i) begin
    map_rd_q <= used_map_q[iss_q[BlkIdxW-1:0]];
    if (map_we) begin
      used_map_q[map_waddr] <= (state_q == SMark);
    end
    if ((state_q == SSlot) && free_found) begin
      dir_key_q[free_idx]    <= key_q;
      dir_start_q[free_idx]  <= StartW'(start_q);
      dir_length_q[free_idx] <= LengthW'(cnt_q);
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      total_q      <= TotalBlocksRst;
      first_q      <= FirstDataRst;
      slot_taken_q <= '0;
      clr_q        <= '0;
      rsp_vld_q    <= 1'b0;
      prim_q       <= 1'b0;
      key_q        <= '0;
      cnt_q        <= '0;
      run_q        <= '0;
      iss_q        <= '0;
      chk_q        <= '0;
      start_q      <= '0;
      mark_q       <= '0;
      left_q       <= '0;
      res_status_q <= StNoSpace;
      res_slot_q   <= '0;
      res_start_q  <= '0;
      rsp_status_q <= '0;
      rsp_slot_q   <= '0;
      rsp_start_q  <= '0;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTotalBlocks:  total_q <= cfg_data_i;
          CfgFirstDataBlk: first_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Output word taken
      if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end

      case (state_q)
        SClear: begin
          clr_q <= clr_q + BlkIdxW'(1);
          if (clr_q == BlkIdxW'(MaxBlocks - 1)) begin
            state_q <= SIdle;
          end
        end

        SIdle: begin
          if (req_acc) begin
            key_q        <= req_i.file_key;
            cnt_q        <= BlkCntW'(req_i.block_count);
            run_q        <= '0;
            iss_q        <= BlkCntW'(first_q);
            chk_q        <= BlkCntW'(first_q);
            prim_q       <= 1'b0;
            res_status_q <= StNoSpace;
            res_slot_q   <= '0;
            res_start_q  <= '0;
            if ((req_i.block_count == '0) || (first_q >= limit)) begin
              state_q <= SResp;
            end else begin
              state_q <= SScan;
            end
          end
        end

        SScan: begin
          if (!prim_q) begin
            // first read in flight
            prim_q <= 1'b1;
            iss_q  <= iss_q + BlkCntW'(1);
          end else if (CfgW'(chk_q) >= limit) begin
            state_q <= SResp;
          end else begin
            iss_q <= iss_q + BlkCntW'(1);
            chk_q <= chk_q + BlkCntW'(1);
            if (map_rd_q) begin
              run_q <= '0;
            end else if (run_inc == cnt_q) begin
              start_q <= BlkIdxW'(chk_q + BlkCntW'(1) - cnt_q);
              state_q <= SSlot;
            end else begin
              run_q <= run_inc;
            end
          end
        end

        SSlot: begin
          if (free_found) begin
            slot_taken_q[free_idx] <= 1'b1;
            res_status_q <= StOk;
            res_slot_q   <= SlotW'(free_idx);
            res_start_q  <= StartW'(start_q);
            mark_q       <= start_q;
            left_q       <= cnt_q;
            state_q      <= SMark;
          end else begin
            res_status_q <= StDirFull;
            state_q      <= SResp;
          end
        end

        SMark: begin
          mark_q <= mark_q + BlkIdxW'(1);
          left_q <= left_q - BlkCntW'(1);
          if (left_q == BlkCntW'(1)) begin
            state_q <= SResp;
          end
        end

        SResp: begin
          // load the output register once it is free
          if (!rsp_vld_q || rsp_o.ready) begin
            rsp_vld_q    <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_slot_q   <= res_slot_q;
            rsp_start_q  <= res_start_q;
            state_q      <= SIdle;
          end
        end

        default: state_q <= SIdle;
      endcase
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.slot        = rsp_slot_q;
  assign rsp_o.start_block = rsp_start_q;

  // A run being counted never reaches the requested length while scanning
  a_run_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (run_q < cnt_q))
    else $error("scan run counter reached request length");

  // A failed request reports neither slot nor start block
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && (rsp_status_q != StOk)) |-> ((rsp_slot_q == '0) && (rsp_start_q == '0)))
    else $error("failed response carries slot or start block");

  // A claimed slot is only ever taken from a free one, and only with a successful result
  a_slot_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SSlot) && free_found) |=> ((state_q == SMark) && (res_status_q == StOk)
      && slot_taken_q[res_slot_q[SlotIdxW-1:0]]))
    else $error("slot claim did not lead to marking");

  // Marking never runs past the end of the map
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMark) |-> ((BlkCntW'(mark_q) + left_q) <= BlkCntW'(MaxBlocks)))
    else $error("marking runs past the used map");

endmodule

`default_nettype wire
